// ----- design/rank_nibble_code_encoder_defines.svh -----
// Assertion macros for the rank nibble code encoder checker.
// No dependencies; included by the checker file.
`ifndef RANK_NIBBLE_CODE_ENCODER_DEFINES_SVH
`define RANK_NIBBLE_CODE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RNCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RNCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rnce_pkg.sv -----
// Package for the rank nibble code encoder: command codes, code limits,
// output queue sizing and the push and queue entry structs. No dependencies.
`default_nettype none

package rnce_pkg;

	localparam logic [1:0] CMD_ENCODE = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	localparam logic [7:0] SHORT_LIMIT = 8'd12;
	localparam logic [7:0] MID_LIMIT   = 8'd60;
	localparam logic [7:0] MID_BASE    = 8'hc0;
	localparam logic [3:0] ESC_NIBBLE  = 4'hf;

	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

	// room for two bytes per item plus two in flight
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	// bytes completed by one item, oldest in b0
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} push_t;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} qent_t;

endpackage

`default_nettype wire

// ----- design/rank_nibble_code_encoder.sv -----
// Rank nibble code encoder, top level.
// Depends on rnce_pkg, rnce_table, rnce_pack and rnce_outq.
//
// Input stream: s_tuser carries the command (encode, load, flush), s_tdata
// carries symbol and rank. Load writes the rank table at the transfer edge;
// encode reads it there and the packer works on the rank in the next cycle.
// Output stream: one packed code byte per transfer, m_tlast on the final
// byte an input item produces. Items that complete no byte produce nothing.
// Output: the table read and valid_s1 are registered, the packer forms the
// bytes, and the queue registers them before m_tvalid rises.
// Throughput: one item per cycle while s_tready is high; an escape code
// adds a second byte, so a run of them drains at one byte per cycle and
// s_tready drops while the eight-entry queue holds more than four bytes.
// When m_tready is low the queue fills and then holds s_tready low; no byte
// is lost. Reset clears the pending half byte and the queue; the rank table
// is not cleared and must be loaded before its entries are encoded.
`default_nettype none

module rank_nibble_code_encoder
	import rnce_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] symbol, [15:8] rank
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast
);

	logic       acc;
	logic [7:0] symbol, rank_in, rank_rd;
	push_t      push;

	assign acc     = s_tvalid & s_tready;
	assign symbol  = s_tdata[7:0];
	assign rank_in = s_tdata[15:8];

	rnce_table u_table (
		.clk     (clk),
		.wr_en   (acc && (s_tuser == CMD_LOAD)),
		.wr_addr (symbol),
		.wr_data (rank_in),
		.rd_en   (acc && (s_tuser == CMD_ENCODE)),
		.rd_addr (symbol),
		.rd_data (rank_rd)
	);

	rnce_pack u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.command (s_tuser),
		.rank_rd (rank_rd),
		.push    (push)
	);

	rnce_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- design/rnce_table.sv -----
// Symbol-to-rank table: 256 x 8 synchronous memory, one write port and
// one registered read port. Uses rnce_pkg.
`default_nettype none

module rnce_table
	import rnce_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [TABLE_AW-1:0] wr_addr,
	input  wire logic [7:0]          wr_data,
	input  wire logic                rd_en,
	input  wire logic [TABLE_AW-1:0] rd_addr,
	output logic      [7:0]          rd_data
);

	logic [7:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/rnce_pack.sv -----
// Nibble packer: takes the rank read from the table in the cycle after the
// transfer, forms the code and packs it with the pending half byte. Uses rnce_pkg.
`default_nettype none

module rnce_pack
	import rnce_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       acc,
	input  wire logic [1:0] command,
	input  wire logic [7:0] rank_rd,
	output push_t           push
);

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [3:0] pend_q, pend_d;
	logic       half_q, half_d;
	logic [7:0] mid_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= CMD_ENCODE;
			pend_q   <= 4'h0;
			half_q   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			cmd_s1   <= command;
			pend_q   <= pend_d;
			half_q   <= half_d;
		end
	end

	assign mid_code = MID_BASE + (rank_rd - SHORT_LIMIT);

	always_comb begin
		push   = '0;
		pend_d = pend_q;
		half_d = half_q;
		if (valid_s1) begin
			case (cmd_s1)
				CMD_ENCODE: begin
					if (rank_rd < SHORT_LIMIT) begin
						if (half_q) begin
							push.cnt = 2'd1;
							push.b0  = {pend_q, rank_rd[3:0]};
							pend_d   = 4'h0;
							half_d   = 1'b0;
						end else begin
							pend_d = rank_rd[3:0];
							half_d = 1'b1;
						end
					end else if (rank_rd < MID_LIMIT) begin
						push.cnt = 2'd1;
						if (half_q) begin
							push.b0 = {pend_q, mid_code[7:4]};
							pend_d  = mid_code[3:0];
						end else begin
							push.b0 = mid_code;
						end
					end else begin
						// escape nibble, then the rank byte
						if (half_q) begin
							push.cnt = 2'd2;
							push.b0  = {pend_q, ESC_NIBBLE};
							push.b1  = rank_rd;
							pend_d   = 4'h0;
							half_d   = 1'b0;
						end else begin
							push.cnt = 2'd1;
							push.b0  = {ESC_NIBBLE, rank_rd[7:4]};
							pend_d   = rank_rd[3:0];
							half_d   = 1'b1;
						end
					end
				end
				CMD_FLUSH: begin
					if (half_q) begin
						push.cnt = 2'd1;
						push.b0  = {pend_q, 4'h0};
						pend_d   = 4'h0;
						half_d   = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/rnce_outq.sv -----
// Output byte queue: takes up to two bytes per cycle, hands out one per
// transfer, and tells the input side when there is room. Uses rnce_pkg.
`default_nettype none

module rnce_outq
	import rnce_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire push_t      push,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_data,
	output logic            out_last
);

	localparam logic [OUTQ_CW-1:0] ROOM_LIMIT = OUTQ_CW'(OUTQ_DEPTH - 4);

	qent_t              mem [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [OUTQ_CW-1:0] count_q;
	logic               pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_ptr_q].data;
	assign out_last  = mem[rd_ptr_q].last;
	assign room      = (count_q <= ROOM_LIMIT);
	assign wr_ptr_nx = wr_ptr_q + OUTQ_AW'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= '{last: (push.cnt == 2'd1), data: push.b0};
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_nx] <= '{last: 1'b1, data: push.b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_AW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			end
			count_q <= count_q + OUTQ_CW'(push.cnt) - OUTQ_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- design/rnce_checker.sv -----
// Port-level checker for the rank nibble code encoder, bound to the top level.
// Depends on rank_nibble_code_encoder_defines.svh.
`default_nettype none
`include "rank_nibble_code_encoder_defines.svh"

module rnce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic        m_tlast
);

	logic       s_xfer;
	logic       m_wait;
	logic [8:0] m_word;
	assign s_xfer = s_tvalid & s_tready;
	assign m_wait = m_tvalid & !m_tready;
	assign m_word = {m_tlast, m_tdata};

	`RNCE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_wait, m_tvalid && $stable(m_word), "output not held")

	// input side only backs up when output bytes are waiting
	`RNCE_ASSERT_SAME(a_stall_has_data, clk, arst_n, !s_tready, m_tvalid, "stall, output empty")

	// nothing accepted at the previous edge and nothing queued: no byte can appear
	`RNCE_ASSERT_NEXT(a_no_spurious, clk, arst_n, !m_tvalid && !$past(s_xfer), !m_tvalid, "spurious byte")

endmodule

bind rank_nibble_code_encoder rnce_checker u_rnce_checker (.*);

`default_nettype wire
